// ===== design/bfhp_pkg.sv =====
// Package for the bitstream file header parser: parse phase type, status and
// field kind codes, and the tag bytes the header format uses. No dependencies.
`default_nettype none

package bfhp_pkg;

    // Parse phases, one-hot
    typedef enum logic [13:0] {
        PH_MLEN_HI = 14'b00000000000001,
        PH_MLEN_LO = 14'b00000000000010,
        PH_MAGIC   = 14'b00000000000100,
        PH_SKIP    = 14'b00000000001000,
        PH_ONE_HI  = 14'b00000000010000,
        PH_ONE_LO  = 14'b00000000100000,
        PH_FTAG    = 14'b00000001000000,
        PH_FLEN_HI = 14'b00000010000000,
        PH_FLEN_LO = 14'b00000100000000,
        PH_FSTR    = 14'b00001000000000,
        PH_ETAG    = 14'b00010000000000,
        PH_BLEN    = 14'b00100000000000,
        PH_DONE    = 14'b01000000000000,
        PH_ERROR   = 14'b10000000000000
    } t_phase;

    typedef logic [1:0] t_status;
    localparam t_status ST_PARSING  = 2'd0;
    localparam t_status ST_COMPLETE = 2'd1;
    localparam t_status ST_ERROR    = 2'd2;
    localparam t_status ST_IDLE     = 2'd3;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_NONE = 3'd0;

    localparam logic [7:0]  TAG_FIRST  = 8'h61; // 'a'
    localparam logic [7:0]  TAG_LENGTH = 8'h65; // 'e'
    localparam logic [7:0]  STR_END    = 8'h00;
    localparam logic [15:0] ONE_WORD   = 16'h0001;

    localparam logic [7:0] EVEN_MAGIC_RESET = 8'h0F;
    localparam logic [7:0] ODD_MAGIC_RESET  = 8'hF0;

    // Register indexes of the configuration port
    localparam logic CFG_EVEN_MAGIC = 1'b0;
    localparam logic CFG_ODD_MAGIC  = 1'b1;

endpackage

`default_nettype wire

// ===== design/bitstream_file_header_parser.sv =====
// Bitstream file header parser, top level. Depends on bfhp_pkg.
// A result item appears on the master side in the cycle after its byte is
// accepted. Throughput: one byte per cycle while the master side keeps up;
// phase update and result come from one pass of small logic on byte and state.
// Reset (i_rst_n low, synchronous) waits for the first magic length byte and
// restores the magic registers to 0x0F (even) and 0xF0 (odd).
`default_nettype none

module bitstream_file_header_parser
    import bfhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [7:0]  i_cfg_wdata,
    // header bytes in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] restart
    // results out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [1:0] status, [9:2] name_byte, [41:10] bitstream_length,
    // [60:42] header_length, [63:61] zero
    output logic [63:0]      m_axis_tdata,
    // [2:0] field_kind, [3] name_byte_valid
    output logic [3:0]       m_axis_tuser
);

    // configuration registers
    logic [7:0]  r_even_magic;
    logic [7:0]  r_odd_magic;

    // parse state
    t_phase      r_phase, n_phase;
    logic [15:0] r_magic_len, n_magic_len;
    logic [15:0] r_field_rem, n_field_rem;
    logic [15:0] r_pos, n_pos;
    logic [18:0] r_bidx, n_bidx;
    logic [31:0] r_len_acc, n_len_acc;
    logic [1:0]  r_field, n_field;      // which of the four string fields
    logic [1:0]  r_blen_cnt, n_blen_cnt; // length byte within tag 'e'

    // result register
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [3:0]  r_out_user;

    // state as seen by this item: a restart clears it first
    t_phase      w_phase;
    logic [15:0] w_magic_len, w_field_rem, w_pos;
    logic [18:0] w_bidx;
    logic [31:0] w_len_acc;
    logic [1:0]  w_field, w_blen_cnt;

    logic [7:0]  w_byte;
    logic        w_accept;
    logic [15:0] w_pos_inc;
    logic [15:0] w_rem_dec;
    logic [31:0] w_len_shift;

    t_status     w_status;
    t_kind       w_kind;
    logic [7:0]  w_nbyte;
    logic        w_nvalid;
    logic [31:0] w_blen;
    logic [18:0] w_hlen;

    // accept whenever the result slot is free or is being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_byte        = s_axis_tdata;

    assign w_phase     = s_axis_tuser ? PH_MLEN_HI : r_phase;
    assign w_magic_len = s_axis_tuser ? 16'd0 : r_magic_len;
    assign w_field_rem = s_axis_tuser ? 16'd0 : r_field_rem;
    assign w_pos       = s_axis_tuser ? 16'd0 : r_pos;
    assign w_bidx      = s_axis_tuser ? 19'd0 : r_bidx;
    assign w_len_acc   = s_axis_tuser ? 32'd0 : r_len_acc;
    assign w_field     = s_axis_tuser ? 2'd0 : r_field;
    assign w_blen_cnt  = s_axis_tuser ? 2'd0 : r_blen_cnt;

    assign w_pos_inc   = w_pos + 16'd1;
    assign w_rem_dec   = w_field_rem - 16'd1;
    assign w_len_shift = {w_len_acc[23:0], w_byte};

    // one parse step for the accepted byte
    always_comb begin
        n_phase    = w_phase;
        n_magic_len = w_magic_len;
        n_field_rem = w_field_rem;
        n_pos      = w_pos;
        n_bidx     = w_bidx + 19'd1;
        n_len_acc  = w_len_acc;
        n_field    = w_field;
        n_blen_cnt = w_blen_cnt;
        w_status   = ST_PARSING;
        w_kind     = KIND_NONE;
        w_nbyte    = 8'd0;
        w_nvalid   = 1'b0;
        w_blen     = 32'd0;
        w_hlen     = 19'd0;

        unique case (w_phase)
            PH_MLEN_HI: begin
                n_magic_len = {w_byte, 8'd0};
                n_phase     = PH_MLEN_LO;
            end
            PH_MLEN_LO: begin
                n_magic_len = {w_magic_len[15:8], w_byte};
                n_pos       = 16'd0;
                if (n_magic_len == 16'd0) begin
                    n_phase = PH_ERROR;
                end else if (n_magic_len == 16'd1) begin
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_MAGIC;
                end
            end
            PH_MAGIC: begin
                if (w_byte != (w_pos[0] ? r_odd_magic : r_even_magic)) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_pos = w_pos_inc;
                    // magic length is at least two here, so the minus one holds
                    if (w_pos_inc >= w_magic_len - 16'd1) begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_phase = PH_ONE_HI;
            end
            PH_ONE_HI: begin
                n_len_acc = {16'd0, w_byte, 8'd0};
                n_phase   = PH_ONE_LO;
            end
            PH_ONE_LO: begin
                n_len_acc = {w_len_acc[31:8], w_byte};
                n_field   = 2'd0;
                n_phase   = (n_len_acc == {16'd0, ONE_WORD}) ? PH_FTAG : PH_ERROR;
            end
            PH_FTAG: begin
                n_phase = (w_byte == TAG_FIRST + {6'd0, w_field}) ? PH_FLEN_HI : PH_ERROR;
            end
            PH_FLEN_HI: begin
                n_field_rem = {w_byte, 8'd0};
                n_phase     = PH_FLEN_LO;
            end
            PH_FLEN_LO: begin
                n_field_rem = {w_field_rem[15:8], w_byte};
                n_phase     = (n_field_rem == 16'd0) ? PH_ERROR : PH_FSTR;
            end
            PH_FSTR: begin
                w_kind      = {1'b0, w_field} + 3'd1;
                w_nbyte     = w_byte;
                w_nvalid    = 1'b1;
                n_field_rem = w_rem_dec;
                if (w_rem_dec == 16'd0) begin
                    if (w_byte != STR_END) begin
                        n_phase = PH_ERROR;
                    end else if (w_field == 2'd3) begin
                        n_phase = PH_ETAG;
                    end else begin
                        n_field = w_field + 2'd1;
                        n_phase = PH_FTAG;
                    end
                end
            end
            PH_ETAG: begin
                n_len_acc  = 32'd0;
                n_blen_cnt = 2'd0;
                n_phase    = (w_byte == TAG_LENGTH) ? PH_BLEN : PH_ERROR;
            end
            PH_BLEN: begin
                n_len_acc = w_len_shift;
                if (w_blen_cnt == 2'd3) begin
                    n_phase  = PH_DONE;
                    w_status = ST_COMPLETE;
                    w_blen   = w_len_shift;
                    w_hlen   = n_bidx;
                end else begin
                    n_blen_cnt = w_blen_cnt + 2'd1;
                end
            end
            default: begin
                // done or error: hold everything and report the byte as ignored
                n_bidx   = w_bidx;
                w_status = ST_IDLE;
            end
        endcase

        if (n_phase == PH_ERROR && w_status != ST_IDLE) begin
            w_status = ST_ERROR;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_even_magic <= EVEN_MAGIC_RESET;
            r_odd_magic  <= ODD_MAGIC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_EVEN_MAGIC: r_even_magic <= i_cfg_wdata;
                CFG_ODD_MAGIC:  r_odd_magic  <= i_cfg_wdata;
                default:        r_even_magic <= r_even_magic;
            endcase
        end
    end

    // parse state: advance only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MLEN_HI;
            r_magic_len <= 16'd0;
            r_field_rem <= 16'd0;
            r_pos       <= 16'd0;
            r_bidx      <= 19'd0;
            r_len_acc   <= 32'd0;
            r_field     <= 2'd0;
            r_blen_cnt  <= 2'd0;
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_magic_len <= n_magic_len;
            r_field_rem <= n_field_rem;
            r_pos       <= n_pos;
            r_bidx      <= n_bidx;
            r_len_acc   <= n_len_acc;
            r_field     <= n_field;
            r_blen_cnt  <= n_blen_cnt;
        end
    end

    // result slot valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    // result payload: load with each accepted item, hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {3'd0, w_hlen, w_blen, w_nbyte, w_status};
            r_out_user <= {w_nvalid, w_kind};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for bitstream_file_header_parser: directed special cases,
// a sender pause mid-header, then random well-formed, corrupted and truncated
// headers under several magic settings. Depends on bfhp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import bfhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    // One result item of the parser, tdata and tuser fields together
    typedef struct packed {
        logic [18:0] hlen;
        logic [31:0] blen;
        logic        nvalid;
        t_kind       kind;
        logic [7:0]  nbyte;
        t_status     status;
    } t_hdr_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = CFG_EVEN_MAGIC;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    // [1:0] status, [9:2] name_byte, [41:10] bitstream_length,
    // [60:42] header_length, [63:61] zero
    logic [63:0] m_axis_tdata;
    // [2:0] field_kind, [3] name_byte_valid
    logic [3:0]  m_axis_tuser;

    always #2 i_clk = ~i_clk;

    bitstream_file_header_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // Parser shadow: magic registers and parse state, at reset values
    // ------------------------------------------------------------------
    logic [7:0]  even_magic = EVEN_MAGIC_RESET;
    logic [7:0]  odd_magic  = ODD_MAGIC_RESET;

    t_phase      phase      = PH_MLEN_HI;
    logic [1:0]  fld_idx    = 2'd0;   // field 'a' .. 'd'
    logic [1:0]  blen_idx   = 2'd0;   // byte of the bitstream length
    logic [15:0] magic_len  = 16'd0;
    logic [15:0] fld_left   = 16'd0;
    logic [15:0] magic_pos  = 16'd0;
    logic [18:0] hdr_bytes  = 19'd0;
    logic [31:0] len_acc    = 32'd0;

    t_hdr_result hdr_result_q[$];
    logic [7:0]  hdr_q[$];            // header bytes being built for sending

    int          bytes_sent      = 0;
    int          results_checked = 0;
    int          errors          = 0;
    int          idle_cycles     = 0;
    int          rx_hold         = 0;
    int          rx_stall;
    bit          rx_fast         = 1'b0;
    bit          tx_fast         = 1'b0;

    // Work out the result item that one accepted header byte causes.
    function automatic t_hdr_result parse_header_byte(logic [7:0] b, logic restart);
        t_hdr_result r;
        r = '0;
        r.status = ST_PARSING;
        if (restart) begin
            phase     = PH_MLEN_HI;
            fld_idx   = 2'd0;
            blen_idx  = 2'd0;
            magic_len = 16'd0;
            fld_left  = 16'd0;
            magic_pos = 16'd0;
            hdr_bytes = 19'd0;
            len_acc   = 32'd0;
        end
        if (phase == PH_DONE || phase == PH_ERROR) begin
            r.status = ST_IDLE;
            return r;
        end
        hdr_bytes = hdr_bytes + 19'd1;
        case (phase)
            PH_MLEN_HI: begin
                magic_len = {b, 8'h00};
                phase = PH_MLEN_LO;
            end
            PH_MLEN_LO: begin
                magic_len[7:0] = b;
                magic_pos = 16'd0;
                if (magic_len == 16'd0)
                    phase = PH_ERROR;
                else if (magic_len == 16'd1)
                    phase = PH_SKIP;    // no magic bytes at all
                else
                    phase = PH_MAGIC;
            end
            PH_MAGIC: begin
                // even positions hold the even value, odd positions the odd one
                if (b != (magic_pos[0] ? odd_magic : even_magic)) begin
                    phase = PH_ERROR;
                end else begin
                    magic_pos = magic_pos + 16'd1;
                    if (magic_pos >= magic_len - 16'd1)
                        phase = PH_SKIP;
                end
            end
            PH_SKIP: phase = PH_ONE_HI;
            PH_ONE_HI: begin
                len_acc = {16'd0, b, 8'h00};
                phase = PH_ONE_LO;
            end
            PH_ONE_LO: begin
                len_acc[7:0] = b;
                phase = (len_acc == {16'd0, ONE_WORD}) ? PH_FTAG : PH_ERROR;
            end
            PH_FTAG: begin
                phase = (b == 8'(TAG_FIRST + {6'd0, fld_idx})) ? PH_FLEN_HI : PH_ERROR;
            end
            PH_FLEN_HI: begin
                fld_left = {b, 8'h00};
                phase = PH_FLEN_LO;
            end
            PH_FLEN_LO: begin
                fld_left[7:0] = b;
                phase = (fld_left == 16'd0) ? PH_ERROR : PH_FSTR;
            end
            PH_FSTR: begin
                // the string byte goes out even when it ends the field badly
                r.kind   = t_kind'({1'b0, fld_idx} + 3'd1);
                r.nbyte  = b;
                r.nvalid = 1'b1;
                fld_left = fld_left - 16'd1;
                if (fld_left == 16'd0) begin
                    if (b != STR_END) begin
                        phase = PH_ERROR;
                    end else if (fld_idx == 2'd3) begin
                        phase = PH_ETAG;
                    end else begin
                        fld_idx = fld_idx + 2'd1;
                        phase = PH_FTAG;
                    end
                end
            end
            PH_ETAG: begin
                len_acc = 32'd0;
                blen_idx = 2'd0;
                phase = (b == TAG_LENGTH) ? PH_BLEN : PH_ERROR;
            end
            PH_BLEN: begin
                len_acc = {len_acc[23:0], b};
                if (blen_idx == 2'd3) begin
                    phase = PH_DONE;
                    r.status = ST_COMPLETE;
                    r.blen = len_acc;
                    r.hlen = hdr_bytes;
                end else begin
                    blen_idx = blen_idx + 2'd1;
                end
            end
            default: r.status = ST_IDLE;
        endcase
        if (phase == PH_ERROR)
            r.status = ST_ERROR;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: predict on every accepted byte, compare every result item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_hdr_result want;
        logic [63:0] want_data;
        logic [3:0]  want_user;
        if (i_rst_n) begin
            // push first so that a result in the same cycle would still match
            if (s_axis_tvalid && s_axis_tready)
                hdr_result_q.push_back(parse_header_byte(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                results_checked++;
                if (hdr_result_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result item: tdata %h tuser %h",
                                 m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = hdr_result_q.pop_front();
                    want_data = {3'b000, want.hlen, want.blen, want.nbyte, want.status};
                    want_user = {want.nvalid, want.kind};
                    if (m_axis_tdata !== want_data || m_axis_tuser !== want_user) begin
                        if (errors < 10)
                            $display({"mismatch on result %0d: status %0d/%0d kind %0d/%0d ",
                                      "byte %h/%h valid %0d/%0d blen %h/%h hlen %0d/%0d ",
                                      "pad %b (expected/actual)"},
                                     results_checked,
                                     want.status, m_axis_tdata[1:0],
                                     want.kind, m_axis_tuser[2:0],
                                     want.nbyte, m_axis_tdata[9:2],
                                     want.nvalid, m_axis_tuser[3],
                                     want.blen, m_axis_tdata[41:10],
                                     want.hlen, m_axis_tdata[60:42],
                                     m_axis_tdata[63:61]);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: after each accepted result item, hold tready low for a random
    // count; now and then switch to a run with no stalls.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_stall = rx_fast ? 0 : $urandom_range(0, 13);
            rx_hold <= rx_stall;
            m_axis_tready <= (rx_stall == 0);
            if ($urandom_range(0, 47) == 0)
                rx_fast <= !rx_fast;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("bitstream_file_header_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks; each is entered right after a rising edge
    // ------------------------------------------------------------------

    // Send one header byte, after a random gap, and hold until accepted.
    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        if ($urandom_range(0, 31) == 0)
            tx_fast = !tx_fast;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // Send the first count bytes of hdr_q; the first one restarts the parser.
    task automatic send_header(input int count);
        for (int i = 0; i < count; i++)
            send_byte(hdr_q[i], i == 0);
    endtask

    // Drop valid and wait until every sent byte has its result item back.
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (results_checked < bytes_sent) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write both magic registers; only called while the parser is idle.
    task automatic write_magic_pair(input logic [7:0] even_val, input logic [7:0] odd_val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_EVEN_MAGIC;
        i_cfg_wdata <= even_val;
        @(posedge i_clk);
        even_magic = even_val;
        i_cfg_addr  <= CFG_ODD_MAGIC;
        i_cfg_wdata <= odd_val;
        @(posedge i_clk);
        odd_magic = odd_val;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Build a well-formed header in hdr_q: mostly short magic and fields,
    // now and then one with a length above 255.
    function automatic void build_header();
        logic [15:0] mlen;
        logic [15:0] flen;
        logic [31:0] blen;
        hdr_q.delete();
        mlen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(256, 300))
                                            : 16'($urandom_range(1, 8));
        hdr_q.push_back(mlen[15:8]);
        hdr_q.push_back(mlen[7:0]);
        for (int p = 0; p < int'(mlen) - 1; p++)
            hdr_q.push_back(p[0] ? odd_magic : even_magic);
        hdr_q.push_back(8'($urandom_range(0, 255)));   // skipped byte
        hdr_q.push_back(ONE_WORD[15:8]);
        hdr_q.push_back(ONE_WORD[7:0]);
        for (int f = 0; f < 4; f++) begin
            flen = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(256, 280))
                                                : 16'($urandom_range(1, 6));
            hdr_q.push_back(8'(TAG_FIRST + f));
            hdr_q.push_back(flen[15:8]);
            hdr_q.push_back(flen[7:0]);
            for (int i = 0; i < int'(flen) - 1; i++)
                hdr_q.push_back(8'($urandom_range(0, 255)));
            hdr_q.push_back(STR_END);
        end
        hdr_q.push_back(TAG_LENGTH);
        blen = $urandom;
        for (int i = 3; i >= 0; i--)
            hdr_q.push_back(blen[8*i +: 8]);
    endfunction

    // Random traffic: mostly good headers, also corrupted and cut-off ones,
    // and some raw noise; up to two random bytes may trail each one.
    task automatic run_random_traffic(input int count);
        int target;
        int pick;
        int idx;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            build_header();
            // cut the header where the byte budget of this run ends
            while (hdr_q.size() > target - bytes_sent)
                void'(hdr_q.pop_back());
            if (pick < 65) begin
                send_header(hdr_q.size());
            end else if (pick < 85) begin
                // flip bits of one random byte anywhere in the header
                idx = $urandom_range(0, hdr_q.size() - 1);
                hdr_q[idx] = hdr_q[idx] ^ 8'($urandom_range(1, 255));
                send_header(hdr_q.size());
            end else if (pick < 95) begin
                send_header($urandom_range(1, hdr_q.size() - 1));
            end else begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 2))
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 39) == 0)
                wait_results_done();
        end
        wait_results_done();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero magic length, ignored byte after error, magic length one with a bad
    // half word, zero field length, and a string ending in a nonzero byte.
    task automatic test_special_cases();
        hdr_q = '{8'h00, 8'h00};
        send_header(hdr_q.size());
        send_byte(8'hFF, 1'b0);
        hdr_q = '{8'h00, 8'h01, 8'hFF, 8'h00, 8'h02};
        send_header(hdr_q.size());
        hdr_q = '{8'h00, 8'h01, 8'h5A, 8'h00, 8'h01, TAG_FIRST, 8'h00, 8'h00};
        send_header(hdr_q.size());
        hdr_q = '{8'h00, 8'h02, EVEN_MAGIC_RESET, 8'hA5, 8'h00, 8'h01,
                  TAG_FIRST, 8'h00, 8'h01, 8'h7E};
        send_header(hdr_q.size());
        wait_results_done();
    endtask

    // Stop the sender halfway through a header until all results are back.
    task automatic test_sender_pause();
        int half;
        build_header();
        half = hdr_q.size() / 2;
        for (int i = 0; i < hdr_q.size(); i++) begin
            if (i == half)
                wait_results_done();
            send_byte(hdr_q[i], i == 0);
        end
        wait_results_done();
    endtask

    // Random traffic under reset magic values, the extremes, alternating bits, an equal pair and random ones.
    task automatic test_magic_settings();
        logic [7:0] same;
        run_random_traffic(110);
        write_magic_pair(8'h00, 8'hFF);
        run_random_traffic(110);
        write_magic_pair(8'hFF, 8'h00);
        run_random_traffic(110);
        write_magic_pair(8'hAA, 8'h55);
        run_random_traffic(110);
        same = 8'($urandom);
        write_magic_pair(same, same);
        run_random_traffic(110);
        write_magic_pair(8'($urandom), 8'($urandom));
        run_random_traffic(110);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_sender_pause();
        test_magic_settings();
        wait_results_done();
        repeat (5) @(posedge i_clk);
        if (hdr_result_q.size() != 0) begin
            $display("%0d expected result items never arrived", hdr_result_q.size());
            errors++;
        end
        if (errors == 0)
            $display("bitstream_file_header_parser regression: pass");
        else
            $display("bitstream_file_header_parser regression: fail");
        $finish;
    end

endmodule
